/* sv/bgtc_pkg.sv */
// Shared types, constants and corner table for the box grid tetra cell generator.
package bgtc_pkg;

  localparam int MAX_CELLS_PER_AXIS = 256;
  localparam int AXIS_W    = 9;
  localparam int CUBE_W    = 24;
  localparam int CORNER_W  = 25;
  localparam int CELL_W    = 27;
  localparam int ROW_W     = 10;
  localparam int PLANE_W   = 17;
  localparam int OFF_W     = 18;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = CUBE_W / DIV_STEPS;
  localparam int TETS      = 6;

  localparam logic [1:0] REG_CELLS_X = 2'd0;
  localparam logic [1:0] REG_CELLS_Y = 2'd1;
  localparam logic [1:0] REG_CELLS_Z = 2'd2;

  typedef struct packed {
    logic [CUBE_W-1:0] cube;
    logic [AXIS_W-1:0] rem_x;
  } side_t;

  typedef struct packed {
    logic [CORNER_W-1:0] base;
    logic [CELL_W-1:0]   cell6;
    logic                err;
  } item_t;

  typedef logic [7:0][OFF_W-1:0] off_tab_t;

  // Corner code of vertex j of tetrahedron k: bit0 +x, bit1 +y, bit2 +z.
  function automatic logic [2:0] tet_code(input logic [2:0] k, input logic [1:0] j);
    logic [11:0] row;
    case (k)
      3'd0:    row = {3'd0, 3'd1, 3'd3, 3'd7};
      3'd1:    row = {3'd0, 3'd1, 3'd7, 3'd5};
      3'd2:    row = {3'd0, 3'd5, 3'd7, 3'd4};
      3'd3:    row = {3'd0, 3'd3, 3'd2, 3'd7};
      3'd4:    row = {3'd0, 3'd6, 3'd4, 3'd7};
      3'd5:    row = {3'd0, 3'd2, 3'd6, 3'd7};
      default: row = 12'd0;
    endcase
    case (j)
      2'd0:    return row[11:9];
      2'd1:    return row[8:6];
      2'd2:    return row[5:3];
      default: return row[2:0];
    endcase
  endfunction

endpackage

/* sv/bgtc_divider.sv */
// Pipelined restoring divider, four quotient bits per stage, with sideband.
module bgtc_divider import bgtc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  logic [CUBE_W-1:0] in_dividend,
  input  logic [AXIS_W-1:0] divisor,
  input  side_t             in_side,
  output logic              out_v,
  output logic [CUBE_W-1:0] out_quot,
  output logic [AXIS_W-1:0] out_rem,
  output side_t             out_side
);

  logic              v_r [DIV_STAGES];
  logic [CUBE_W-1:0] n_r [DIV_STAGES];
  logic [CUBE_W-1:0] q_r [DIV_STAGES];
  logic [AXIS_W-1:0] r_r [DIV_STAGES];
  side_t             s_r [DIV_STAGES];

  logic              v_nxt [DIV_STAGES];
  logic [CUBE_W-1:0] n_nxt [DIV_STAGES];
  logic [CUBE_W-1:0] q_nxt [DIV_STAGES];
  logic [AXIS_W-1:0] r_nxt [DIV_STAGES];
  side_t             s_nxt [DIV_STAGES];

  always_comb begin
    logic [CUBE_W-1:0] n;
    logic [CUBE_W-1:0] q;
    logic [AXIS_W-1:0] r;
    logic [AXIS_W:0]   tmp;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        n = in_dividend;
        q = '0;
        r = '0;
        v_nxt[s] = in_v;
        s_nxt[s] = in_side;
      end else begin
        n = n_r[s-1];
        q = q_r[s-1];
        r = r_r[s-1];
        v_nxt[s] = v_r[s-1];
        s_nxt[s] = s_r[s-1];
      end
      for (int i = 0; i < DIV_STEPS; i++) begin
        tmp = {r, n[CUBE_W-1]};
        n = {n[CUBE_W-2:0], 1'b0};
        if (tmp >= {1'b0, divisor}) begin
          tmp = tmp - {1'b0, divisor};
          q = {q[CUBE_W-2:0], 1'b1};
        end else begin
          q = {q[CUBE_W-2:0], 1'b0};
        end
        r = tmp[AXIS_W-1:0];
      end
      n_nxt[s] = n;
      q_nxt[s] = q;
      r_nxt[s] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STAGES; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s < DIV_STAGES; s++) v_r[s] <= v_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        n_r[s] <= n_nxt[s];
        q_r[s] <= q_nxt[s];
        r_r[s] <= r_nxt[s];
        s_r[s] <= s_nxt[s];
      end
    end
  end

  assign out_v    = v_r[DIV_STAGES-1];
  assign out_quot = q_r[DIV_STAGES-1];
  assign out_rem  = r_r[DIV_STAGES-1];
  assign out_side = s_r[DIV_STAGES-1];

endmodule

/* sv/bgtc_emitter.sv */
// Output stage: holds one cube and hands out its six tetrahedra in turn, or one error result.
module bgtc_emitter import bgtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_v,
  input  item_t               in_item,
  input  off_tab_t            off_tab,
  output logic                adv,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [CORNER_W-1:0] out_corner_a,
  output logic [CORNER_W-1:0] out_corner_b,
  output logic [CORNER_W-1:0] out_corner_c,
  output logic [CORNER_W-1:0] out_corner_d,
  output logic [CELL_W-1:0]   out_cell_number,
  output logic                out_last_of_run,
  output logic                out_range_error
);

  logic        busy_r;
  item_t       item_r;
  logic [2:0]  k_r;
  logic [2:0]  k_nxt;
  logic        last;

  assign last = item_r.err || (k_r == 3'(TETS - 1));
  assign adv  = !busy_r || (!out_stall && last);

  always_comb begin
    k_nxt = k_r;
    if (adv) k_nxt = '0;
    else if (!out_stall) k_nxt = k_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      if (adv) busy_r <= in_v;
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) item_r <= in_item;
  end

  function automatic logic [CORNER_W-1:0] corner(input logic [CORNER_W-1:0] base,
                                                  input logic [OFF_W-1:0] off);
    return base + CORNER_W'(off);
  endfunction

  always_comb begin
    out_valid       = busy_r;
    out_last_of_run = last;
    out_range_error = item_r.err;
    if (item_r.err) begin
      out_corner_a    = '0;
      out_corner_b    = '0;
      out_corner_c    = '0;
      out_corner_d    = '0;
      out_cell_number = '0;
    end else begin
      out_corner_a    = corner(item_r.base, off_tab[tet_code(k_r, 2'd0)]);
      out_corner_b    = corner(item_r.base, off_tab[tet_code(k_r, 2'd1)]);
      out_corner_c    = corner(item_r.base, off_tab[tet_code(k_r, 2'd2)]);
      out_corner_d    = corner(item_r.base, off_tab[tet_code(k_r, 2'd3)]);
      out_cell_number = item_r.cell6 + CELL_W'(k_r);
    end
  end

endmodule

/* sv/box_grid_tetra_cell_generator_core.sv */
// Top level of the box grid tetra cell generator: config, index split and vertex math.
//
// Use: push one cube number per request on the in_ channel (in_valid, in_stall).
// The block splits it into x, y, z cell coordinates (x fastest), forms the
// cube's lowest vertex number on the (cx+1)(cy+1)(cz+1) lattice and emits six
// tetrahedra on the out_ channel, one per cycle while out_stall is low, the sixth marked last_of_run.
// A cube number outside the grid gives one result with range_error and
// last_of_run set and all other fields zero.
// Config: write cells_x / cells_y / cells_z through cfg_ (index 0..2, ready is
// always high) only while the block is idle; values above 256 saturate.
// Pipeline: two 6-stage dividers, one multiply stage and one add stage, then
// 6 results back to back from the emitter while out_stall is low (one for an out-of-grid cube).
// Throughput is set by the single-result output port, which hands out a cube's
// results in turn. Requests are taken while earlier cubes are still in the dividers.
// Stall: when out_stall holds the result, the whole pipeline freezes and
// in_stall rises; nothing is dropped or repeated.
// Reset (synchronous, rst_n low): all pipeline valids clear, axis registers
// return to 1. Derived offsets follow a config write through row_r, plane_r and off_r.
module box_grid_tetra_cell_generator_core import bgtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [AXIS_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CUBE_W-1:0]   in_cube_number,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CORNER_W-1:0] out_corner_a,
  output logic [CORNER_W-1:0] out_corner_b,
  output logic [CORNER_W-1:0] out_corner_c,
  output logic [CORNER_W-1:0] out_corner_d,
  output logic [CELL_W-1:0]   out_cell_number,
  output logic                out_last_of_run,
  output logic                out_range_error
);

  logic [AXIS_W-1:0] cx_r, cy_r, cz_r;
  logic [AXIS_W-1:0] cfg_sat;
  logic [ROW_W-1:0]  row_r;
  logic [PLANE_W-1:0] plane_r;
  off_tab_t          off_r;
  off_tab_t          off_nxt;
  logic              adv;

  // Config write: saturate to the axis maximum.
  assign cfg_ready = 1'b1;
  assign cfg_sat = (cfg_data > AXIS_W'(MAX_CELLS_PER_AXIS)) ?
                   AXIS_W'(MAX_CELLS_PER_AXIS) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= AXIS_W'(1);
      cy_r <= AXIS_W'(1);
      cz_r <= AXIS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELLS_X: cx_r <= cfg_sat;
        REG_CELLS_Y: cy_r <= cfg_sat;
        REG_CELLS_Z: cz_r <= cfg_sat;
        default: ;
      endcase
    end
  end

  // Lattice strides and corner offsets follow the axis registers.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      off_nxt[c] = OFF_W'(c & 1)
                 + (((c & 2) != 0) ? OFF_W'(row_r) : '0)
                 + (((c & 4) != 0) ? OFF_W'(plane_r) : '0);
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= ROW_W'(cx_r) + ROW_W'(1);
    plane_r <= PLANE_W'(row_r) * (PLANE_W'(cy_r) + PLANE_W'(1));
    off_r   <= off_nxt;
  end

  assign in_stall = !adv;

  // First split: cube / cells_x gives ix and the row number.
  logic              d1_v;
  logic [CUBE_W-1:0] d1_q;
  logic [AXIS_W-1:0] d1_r;
  side_t             d1_s;
  side_t             in_side;

  assign in_side.cube  = in_cube_number;
  assign in_side.rem_x = '0;

  bgtc_divider u_div_x (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_v(in_valid), .in_dividend(in_cube_number), .divisor(cx_r), .in_side(in_side),
    .out_v(d1_v), .out_quot(d1_q), .out_rem(d1_r), .out_side(d1_s)
  );

  // Second split: row / cells_y gives iy and iz.
  side_t             d2_in_side;
  logic              d2_v;
  logic [CUBE_W-1:0] d2_q;
  logic [AXIS_W-1:0] d2_r;
  side_t             d2_s;

  assign d2_in_side.cube  = d1_s.cube;
  assign d2_in_side.rem_x = d1_r;

  bgtc_divider u_div_y (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_v(d1_v), .in_dividend(d1_q), .divisor(cy_r), .in_side(d2_in_side),
    .out_v(d2_v), .out_quot(d2_q), .out_rem(d2_r), .out_side(d2_s)
  );

  // Multiply stage: z and y strides. Out of grid when iz reaches cells_z or any axis is zero.
  logic                      m_v_r;
  logic [AXIS_W+PLANE_W-1:0] m_a_r;
  logic [AXIS_W+ROW_W-1:0]   m_b_r;
  logic [AXIS_W-1:0]         m_ix_r;
  logic [CUBE_W-1:0]         m_cube_r;
  logic                      m_err_r;
  logic                      m_err_nxt;

  assign m_err_nxt = (cx_r == '0) || (cy_r == '0) || (cz_r == '0) ||
                     (d2_q >= CUBE_W'(cz_r));

  // Add stage: lowest vertex and six times the cube number.
  logic   a_v_r;
  item_t  a_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      a_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= d2_v;
      a_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a_r    <= d2_q[AXIS_W-1:0] * plane_r;
      m_b_r    <= d2_r * row_r;
      m_ix_r   <= d2_s.rem_x;
      m_cube_r <= d2_s.cube;
      m_err_r  <= m_err_nxt;
      a_item_r.base  <= CORNER_W'(m_a_r) + CORNER_W'(m_b_r) + CORNER_W'(m_ix_r);
      a_item_r.cell6 <= (CELL_W'(m_cube_r) << 2) + (CELL_W'(m_cube_r) << 1);
      a_item_r.err   <= m_err_r;
    end
  end

  bgtc_emitter u_emit (
    .clk(clk), .rst_n(rst_n),
    .in_v(a_v_r), .in_item(a_item_r), .off_tab(off_r), .adv(adv),
    .out_stall(out_stall), .out_valid(out_valid),
    .out_corner_a(out_corner_a), .out_corner_b(out_corner_b),
    .out_corner_c(out_corner_c), .out_corner_d(out_corner_d),
    .out_cell_number(out_cell_number), .out_last_of_run(out_last_of_run),
    .out_range_error(out_range_error)
  );

  // An error result always closes its run.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_last_of_run)
    else $error("range error result without last_of_run");

  // Within a run, tetrahedron numbers advance by one.
  a_cell_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_valid && (out_cell_number == $past(out_cell_number) + CELL_W'(1)))
    else $error("cell number did not advance within a run");

  // Input back-pressure only while a result is pending.
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

/* verif/box_grid_tetra_cell_generator_core_chk.sv */
// Result checker for the box grid tetra cell generator: predicts tetrahedra and compares.
`timescale 1ns / 1ps
module box_grid_tetra_cell_generator_core_chk import bgtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [AXIS_W-1:0]   cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [CUBE_W-1:0]   in_cube_number,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [CORNER_W-1:0] out_corner_a,
  input  logic [CORNER_W-1:0] out_corner_b,
  input  logic [CORNER_W-1:0] out_corner_c,
  input  logic [CORNER_W-1:0] out_corner_d,
  input  logic [CELL_W-1:0]   out_cell_number,
  input  logic                out_last_of_run,
  input  logic                out_range_error,
  output int                  mismatches,
  output int                  tets_pending,
  output int                  tets_seen,
  output int                  errors_seen
);

  typedef struct packed {
    logic [CORNER_W-1:0] a, b, c, d;
    logic [CELL_W-1:0]   cell_no;
    logic                last;
    logic                err;
  } tet_t;

  tet_t tet_queue[$];
  logic [AXIS_W-1:0] grid_x, grid_y, grid_z;

  localparam logic [2:0] KUHN [6][4] = '{
    '{3'd0, 3'd1, 3'd3, 3'd7}, '{3'd0, 3'd1, 3'd7, 3'd5}, '{3'd0, 3'd5, 3'd7, 3'd4},
    '{3'd0, 3'd3, 3'd2, 3'd7}, '{3'd0, 3'd6, 3'd4, 3'd7}, '{3'd0, 3'd2, 3'd6, 3'd7}};

  function automatic logic [AXIS_W-1:0] clamp_axis(logic [AXIS_W-1:0] v);
    return (v > MAX_CELLS_PER_AXIS) ? AXIS_W'(MAX_CELLS_PER_AXIS) : v;
  endfunction

  task automatic split_cube(input logic [CUBE_W-1:0] cube);
    longint unsigned total, ix, iy, iz, row, plane, base;
    longint unsigned corner[8];
    tet_t t;
    total = longint'(grid_x) * grid_y * grid_z;
    if (cube >= total) begin
      t = '0;
      t.last = 1'b1;
      t.err = 1'b1;
      tet_queue.push_back(t);
      return;
    end
    ix = cube % grid_x;
    iy = (cube / grid_x) % grid_y;
    iz = cube / (longint'(grid_x) * grid_y);
    row = grid_x + 1;
    plane = row * (grid_y + 1);
    base = iz * plane + iy * row + ix;
    for (int j = 0; j < 8; j++)
      corner[j] = base + (j[0] ? 1 : 0) + (j[1] ? row : 0) + (j[2] ? plane : 0);
    for (int k = 0; k < 6; k++) begin
      t.a = CORNER_W'(corner[KUHN[k][0]]);
      t.b = CORNER_W'(corner[KUHN[k][1]]);
      t.c = CORNER_W'(corner[KUHN[k][2]]);
      t.d = CORNER_W'(corner[KUHN[k][3]]);
      t.cell_no = CELL_W'(longint'(cube) * 6 + k);
      t.last = (k == 5);
      t.err = 1'b0;
      tet_queue.push_back(t);
    end
  endtask

  assign tets_pending = tet_queue.size();

  always @(posedge clk) begin
    tet_t want, got;
    if (!rst_n) begin
      grid_x <= AXIS_W'(1);
      grid_y <= AXIS_W'(1);
      grid_z <= AXIS_W'(1);
      tet_queue.delete();
      mismatches <= 0;
      tets_seen <= 0;
      errors_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CELLS_X: grid_x <= clamp_axis(cfg_data);
          REG_CELLS_Y: grid_y <= clamp_axis(cfg_data);
          REG_CELLS_Z: grid_z <= clamp_axis(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{out_corner_a, out_corner_b, out_corner_c, out_corner_d,
                out_cell_number, out_last_of_run, out_range_error};
        tets_seen <= tets_seen + 1;
        if (out_range_error) errors_seen <= errors_seen + 1;
        if (tet_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = tet_queue.pop_front();
          if (got !== want) begin
            if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      // Predict after the pop so a same-edge request lands behind older ones.
      if (in_valid && !in_stall) split_cube(in_cube_number);
    end
  end

endmodule

/* verif/box_grid_tetra_cell_generator_core_tb.sv */
// Stimulus and verdict for the box grid tetra cell generator regression.
`timescale 1ns / 1ps
module box_grid_tetra_cell_generator_core_tb;
  import bgtc_pkg::*;

  logic clk = 0, rst_n = 0;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = REG_CELLS_X;
  logic [AXIS_W-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [CUBE_W-1:0] in_cube_number = '0;
  logic out_valid, out_stall = 0;
  logic [CORNER_W-1:0] out_corner_a, out_corner_b, out_corner_c, out_corner_d;
  logic [CELL_W-1:0] out_cell_number;
  logic out_last_of_run, out_range_error;
  int mismatches, tets_pending, tets_seen, errors_seen;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int cycles = 0;
  int grids = 0;
  localparam int CYCLE_LIMIT = 400000;

  always #5 clk = ~clk;

  box_grid_tetra_cell_generator_core uut (.*);
  box_grid_tetra_cell_generator_core_chk chk (.*);

  // Receiver: stall at random on the falling edge.
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Hard stop so a hung pipeline cannot run forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("box_grid_tetra_cell_generator_core regression: fail");
      $finish;
    end
  end

  // Send one request and hold it until accepted; the next call or a drain ends it.
  task automatic send_cube(input logic [CUBE_W-1:0] cube);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_cube_number <= cube;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait until all tetrahedra are back, then let the pipeline drain.
  task automatic drain;
    in_valid <= 0;
    while (tets_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_axis(input logic [1:0] idx, input logic [AXIS_W-1:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    // Let derived offsets settle.
    repeat (3) @(negedge clk);
  endtask

  task automatic set_grid(input int x, input int y, input int z);
    drain();
    write_axis(REG_CELLS_X, AXIS_W'(x));
    write_axis(REG_CELLS_Y, AXIS_W'(y));
    write_axis(REG_CELLS_Z, AXIS_W'(z));
    grids++;
  endtask

  // Mostly in-grid cubes with random content; a few out of range and full-width noise.
  task automatic random_cubes(input int n, input int x, input int y, input int z);
    int total;
    total = x * y * z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       send_cube(CUBE_W'($urandom()));
        1:       send_cube(CUBE_W'(total + int'($urandom_range(3))));
        2:       send_cube(CUBE_W'(total - 1));
        default: send_cube(CUBE_W'($urandom_range(total - 1)));
      endcase
    end
  endtask

  initial begin
    int sx, sy, sz;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: reset grid of one cube, then extremes, saturation, an empty grid and a small grid.
    send_cube(0);
    send_cube(1);
    send_cube(24'hFFFFFF);
    set_grid(256, 256, 256);
    send_cube(0);
    send_cube(24'hFFFFFF);
    send_cube(24'hAAAAAA);
    send_cube(24'h555555);
    send_cube(255);
    send_cube(256);
    send_cube(65535);
    send_cube(65536);
    set_grid(511, 300, 257);   // saturate every axis to 256
    send_cube(24'hFFFFFF);
    send_cube(24'h123456);
    set_grid(0, 5, 5);         // empty grid: every cube is an error
    send_cube(0);
    send_cube(7);
    set_grid(3, 2, 4);
    for (int i = 0; i < 6; i++) send_cube(CUBE_W'(i * 4));
    send_cube(23);
    send_cube(24);

    // Random phases: receiver-heavy idle, sender-heavy idle, then full rate.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 16 : 0;
      for (int g = 0; g < 4; g++) begin
        sx = (g == 0) ? 1 : $urandom_range(1, 20);
        sy = (g == 3) ? 256 : $urandom_range(1, 20);
        sz = $urandom_range(1, 20);
        set_grid(sx, sy, sz);
        random_cubes(20, sx, sy, sz);
        // Hold off until the pipeline is empty once per grid.
        in_valid <= 0;
        @(negedge clk);
        while (tets_pending != 0) @(negedge clk);
        random_cubes(20, sx, sy, sz);
      end
    end
    set_grid(256, 256, 256);
    random_cubes(20, 256, 256, 256);
    drain();

    $display("covered %0d grid settings, %0d tetrahedra checked, %0d range errors",
             grids, tets_seen, errors_seen);
    if (mismatches == 0) begin
      $display("box_grid_tetra_cell_generator_core regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("box_grid_tetra_cell_generator_core regression: fail");
    end
    $finish;
  end

endmodule
